// ----- hw/rtl/multi_channel_pwm_generator_top_assert.svh -----
// Assertion macros for the PWM channel table block.
// Included by multi_channel_pwm_generator_top; depends on nothing else.
`ifndef MULTI_CHANNEL_PWM_GENERATOR_TOP_ASSERT_SVH
`define MULTI_CHANNEL_PWM_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define MCPWM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mcpwm assertion failed");
// Next-cycle implication, checked outside reset.
`define MCPWM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mcpwm assertion failed");
`else
`define MCPWM_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define MCPWM_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/mcpwm_pkg.sv -----
// Package for the PWM channel table block: item codes, status codes,
// sequencer states and the pin drive helper. Depends on nothing.
package mcpwm_pkg;

  localparam int PIN_W   = 5;
  localparam int TICK_W  = 16;
  localparam int MASK_W  = 17;
  localparam int TOP_PIN = 16;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ARGS = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_PIN   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_APPLY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [MASK_W-1:0] clr_m;
    logic [MASK_W-1:0] set_m;
  } drv_t;

  // Drive one pin to a level; pins above the top pin have no mask bit.
  function automatic drv_t drive(drv_t d, logic [PIN_W-1:0] pin, logic level);
    logic [MASK_W-1:0] b;
    drv_t r;
    b = (pin > PIN_W'(TOP_PIN)) ? '0 : (MASK_W'(1) << pin);
    r = d;
    r.set_m = r.set_m & ~b;
    r.clr_m = r.clr_m & ~b;
    if (level) begin
      r.set_m = r.set_m | b;
    end else begin
      r.clr_m = r.clr_m | b;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/mcpwm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the channel slot records.
module mcpwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/multi_channel_pwm_generator_top.sv -----
// Multi-channel PWM generator: slot table in RAM walked by a small sequencer.
// Depends on mcpwm_pkg, mcpwm_ram and multi_channel_pwm_generator_top_assert.svh.
//
//   channel | direction | tdata (low bit up)                          | tuser
//   in_     | slave     | pin[4:0] period[20:5] duty[36:21] 0[39:37]  | op[0]
//   out_    | master    | status[1:0] set[18:2] clr[35:19] run[36]    | -
//
// A running tick or an accepted set walks every slot, one read per cycle from the slot RAM;
// a set then passes through an apply step, and every item ends in a result step.
// A rejected set or a tick while no channel toggles skips the walk and goes to the result step.
// Reset (rst_n low, synchronous) frees every slot and stops the timer.
// The result sits in an output register; a stalled output holds the next item
// in its final step until the register frees.
`include "multi_channel_pwm_generator_top_assert.svh"

module multi_channel_pwm_generator_top #(
  parameter int CHANNELS   = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pin, period_ticks, duty_ticks, zero pad
  input  logic [0:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status, set_mask, clear_mask, timer_running, pad
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW = $clog2(CHANNELS + 1);
  localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int PW = mcpwm_pkg::PIN_W;
  localparam int TW = mcpwm_pkg::TICK_W;

  typedef struct packed {
    logic [PW-1:0]         pin;
    logic                  level;
    logic [COUNT_BITS-1:0] count;
    logic [TW-1:0]         period;
    logic [TW-1:0]         duty;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Sequencer and item registers
  mcpwm_pkg::state_t  state_r, state_nxt;
  mcpwm_pkg::op_t     op_r, op_nxt;
  logic [PW-1:0]      pin_r, pin_nxt;
  logic [TW-1:0]      period_r, period_nxt;
  logic [TW-1:0]      duty_r, duty_nxt;
  mcpwm_pkg::status_t status_r, status_nxt;
  mcpwm_pkg::drv_t    drv_r, drv_nxt;

  // Walk control
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               proc_vld_r, proc_vld_nxt;
  logic [AW-1:0]      proc_idx_r, proc_idx_nxt;
  logic               match_vld_r, match_vld_nxt;
  logic [AW-1:0]      match_idx_r, match_idx_nxt;
  rec_t               match_rec_r, match_rec_nxt;
  logic               free_vld_r, free_vld_nxt;
  logic [AW-1:0]      free_idx_r, free_idx_nxt;

  // Per-slot flags: slot in use, channel toggles on ticks
  logic [CHANNELS-1:0] used_r, used_nxt;
  logic [CHANNELS-1:0] tog_r, tog_nxt;

  // Output register
  logic               out_vld_r, out_vld_nxt;
  logic [39:0]        out_data_r, out_data_nxt;

  // RAM port
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  rec_t               ram_wdata;
  logic [REC_W-1:0]   ram_rdata;
  rec_t               rd_rec;

  // Datapath helpers
  mcpwm_pkg::op_t     in_op;
  logic [PW-1:0]      in_pin;
  logic [TW-1:0]      in_period, in_duty;
  logic               in_bad, ticking, walk_end, out_free;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic [TW-1:0]      tick_gap;
  logic               tick_flip;
  rec_t               tick_rec;
  logic [AW-1:0]      apply_slot;
  rec_t               apply_rec, apply_wr;

  assign in_op     = mcpwm_pkg::op_t'(in_tuser[0]);
  assign in_pin    = in_tdata[4:0];
  assign in_period = in_tdata[20:5];
  assign in_duty   = in_tdata[36:21];
  assign in_bad    = (in_period != '0) &&
                     ((in_period < TW'(2)) || (in_duty > in_period));
  assign ticking   = |tog_r;
  assign walk_end  = (idx_r == IW'(CHANNELS)) && !proc_vld_r;
  assign out_free  = !out_vld_r || out_tready;

  assign in_tready  = (state_r == mcpwm_pkg::S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Tick step on the slot whose record just came out of the RAM
  assign rd_rec    = rec_t'(ram_rdata);
  assign cnt_dec   = rd_rec.count - COUNT_BITS'(1);
  assign tick_gap  = rd_rec.period - rd_rec.duty;
  assign tick_flip = (cnt_dec == '0) && (rd_rec.duty != '0) &&
                     (rd_rec.duty != rd_rec.period);

  always_comb begin
    tick_rec = rd_rec;
    if (tick_flip) begin
      tick_rec.level = ~rd_rec.level;
      tick_rec.count = (~rd_rec.level) ? COUNT_BITS'(rd_rec.duty)
                                       : COUNT_BITS'(tick_gap);
    end else begin
      tick_rec.count = cnt_dec;
    end
  end

  // Set target: the slot that holds the pin, else the first free slot
  assign apply_slot = match_vld_r ? match_idx_r : free_idx_r;

  always_comb begin
    apply_rec = '0;
    apply_rec.pin = pin_r;
    if (match_vld_r) begin
      apply_rec = match_rec_r;
    end
  end

  mcpwm_ram #(
    .WIDTH (REC_W),
    .DEPTH (CHANNELS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcpwm_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (in_op == mcpwm_pkg::OP_SET) begin
            state_nxt = in_bad ? mcpwm_pkg::S_DONE : mcpwm_pkg::S_WALK;
          end else begin
            state_nxt = ticking ? mcpwm_pkg::S_WALK : mcpwm_pkg::S_DONE;
          end
        end
      end
      mcpwm_pkg::S_WALK: begin
        if (walk_end) begin
          state_nxt = (op_r == mcpwm_pkg::OP_SET) ? mcpwm_pkg::S_APPLY
                                                  : mcpwm_pkg::S_DONE;
        end
      end
      mcpwm_pkg::S_APPLY: begin
        state_nxt = mcpwm_pkg::S_DONE;
      end
      mcpwm_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = mcpwm_pkg::S_IDLE;
        end
      end
      default: state_nxt = mcpwm_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    op_nxt        = op_r;
    pin_nxt       = pin_r;
    period_nxt    = period_r;
    duty_nxt      = duty_r;
    status_nxt    = status_r;
    drv_nxt       = drv_r;
    idx_nxt       = idx_r;
    proc_vld_nxt  = 1'b0;
    proc_idx_nxt  = proc_idx_r;
    match_vld_nxt = match_vld_r;
    match_idx_nxt = match_idx_r;
    match_rec_nxt = match_rec_r;
    free_vld_nxt  = free_vld_r;
    free_idx_nxt  = free_idx_r;
    used_nxt      = used_r;
    tog_nxt       = tog_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = proc_idx_r;
    ram_wdata     = tick_rec;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[AW-1:0];
    apply_wr      = apply_rec;

    unique case (state_r)
      mcpwm_pkg::S_IDLE: begin
        if (in_tvalid) begin
          // Latch the item and clear the walk results
          op_nxt        = in_op;
          pin_nxt       = in_pin;
          period_nxt    = in_period;
          duty_nxt      = in_duty;
          drv_nxt       = '0;
          idx_nxt       = '0;
          match_vld_nxt = 1'b0;
          free_vld_nxt  = 1'b0;
          status_nxt    = (in_op == mcpwm_pkg::OP_SET && in_bad) ?
                          mcpwm_pkg::ST_BAD_ARGS : mcpwm_pkg::ST_OK;
        end
      end

      mcpwm_pkg::S_WALK: begin
        // Issue the next read; the record comes back in the following cycle
        if (idx_r < IW'(CHANNELS)) begin
          ram_re       = 1'b1;
          idx_nxt      = idx_r + IW'(1);
          proc_vld_nxt = 1'b1;
          proc_idx_nxt = idx_r[AW-1:0];
        end
        if (proc_vld_r) begin
          if (op_r == mcpwm_pkg::OP_TICK) begin
            if (used_r[proc_idx_r]) begin
              ram_we = 1'b1;
              if (tick_flip) begin
                drv_nxt = mcpwm_pkg::drive(drv_r, rd_rec.pin, tick_rec.level);
              end
            end
          end else begin
            if (used_r[proc_idx_r] && rd_rec.pin == pin_r && !match_vld_r) begin
              match_vld_nxt = 1'b1;
              match_idx_nxt = proc_idx_r;
              match_rec_nxt = rd_rec;
            end
            if (!used_r[proc_idx_r] && !free_vld_r) begin
              free_vld_nxt = 1'b1;
              free_idx_nxt = proc_idx_r;
            end
          end
        end
      end

      mcpwm_pkg::S_APPLY: begin
        if (period_r == '0) begin
          // Remove the channel and drive its pin low
          if (match_vld_r) begin
            used_nxt[apply_slot] = 1'b0;
            tog_nxt[apply_slot]  = 1'b0;
            drv_nxt = mcpwm_pkg::drive(drv_r, pin_r, 1'b0);
          end else begin
            status_nxt = mcpwm_pkg::ST_NO_PIN;
          end
        end else if (!match_vld_r && !free_vld_r) begin
          status_nxt = mcpwm_pkg::ST_FULL;
        end else begin
          used_nxt[apply_slot] = 1'b1;
          if (!(apply_rec.period == period_r && apply_rec.duty == duty_r)) begin
            apply_wr.period = period_r;
            apply_wr.duty   = duty_r;
            // Restart high when the counter is spent or beyond the new period
            if (apply_rec.count == '0 || CW'(apply_rec.count) > CW'(period_r)) begin
              apply_wr.level = 1'b1;
              apply_wr.count = COUNT_BITS'(duty_r);
              drv_nxt = mcpwm_pkg::drive(drv_nxt, pin_r, 1'b1);
            end
            if (duty_r == '0 || duty_r == period_r) begin
              drv_nxt = mcpwm_pkg::drive(drv_nxt, pin_r, duty_r == period_r);
            end
            ram_we    = 1'b1;
            ram_waddr = apply_slot;
            ram_wdata = apply_wr;
            tog_nxt[apply_slot] = (duty_r != '0) && (duty_r != period_r);
          end
        end
      end

      mcpwm_pkg::S_DONE: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {3'b000, ticking, drv_r.clr_m, drv_r.set_m, status_r};
        end
      end

      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mcpwm_pkg::S_IDLE;
      out_vld_r  <= 1'b0;
      used_r     <= '0;
      tog_r      <= '0;
      proc_vld_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      out_vld_r  <= out_vld_nxt;
      used_r     <= used_nxt;
      tog_r      <= tog_nxt;
      proc_vld_r <= proc_vld_nxt;
      idx_r      <= idx_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pin_r       <= pin_nxt;
    period_r    <= period_nxt;
    duty_r      <= duty_nxt;
    status_r    <= status_nxt;
    drv_r       <= drv_nxt;
    proc_idx_r  <= proc_idx_nxt;
    match_vld_r <= match_vld_nxt;
    match_idx_r <= match_idx_nxt;
    match_rec_r <= match_rec_nxt;
    free_vld_r  <= free_vld_nxt;
    free_idx_r  <= free_idx_nxt;
    out_data_r  <= out_data_nxt;
  end

  `MCPWM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `MCPWM_ASSERT_IMP(a_masks_disjoint, clk, rst_n, out_vld_r, (out_data_r[18:2] & out_data_r[35:19]) == '0)
  `MCPWM_ASSERT_IMP(a_reject_no_drive, clk, rst_n, out_vld_r && out_data_r[1:0] != mcpwm_pkg::ST_OK, out_data_r[35:2] == '0)
  `MCPWM_ASSERT_IMP(a_walk_bound, clk, rst_n, state_r == mcpwm_pkg::S_WALK, idx_r <= IW'(CHANNELS))
  `MCPWM_ASSERT_IMP(a_match_in_use, clk, rst_n, state_r == mcpwm_pkg::S_APPLY && match_vld_r, used_r[match_idx_r])
  `MCPWM_ASSERT_IMP(a_toggle_in_use, clk, rst_n, state_r == mcpwm_pkg::S_IDLE, (tog_r & ~used_r) == '0)

endmodule

// ----- tb/pwm_table_checker.sv -----
// Result checker for the PWM channel table block: predicts each result from accepted
// items and compares it with the result stream. Depends on mcpwm_pkg.
module pwm_table_checker
  import mcpwm_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          checked_count,
  output int          pin_edges
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    status_t           status;
    logic [MASK_W-1:0] set_m;
    logic [MASK_W-1:0] clr_m;
    logic              running;
  } pwm_result_t;

  pwm_result_t       expected_drives[$];

  logic              used[CHANNELS];
  logic [PIN_W-1:0]  pin_of[CHANNELS];
  logic              level_of[CHANNELS];
  logic [TICK_W-1:0] count_of[CHANNELS];
  logic [TICK_W-1:0] period_of[CHANNELS];
  logic [TICK_W-1:0] duty_of[CHANNELS];
  logic              ticking;
  int                mismatches;

  function automatic void drive_pin(input logic [PIN_W-1:0] pin, input logic level,
                                    inout logic [MASK_W-1:0] set_m,
                                    inout logic [MASK_W-1:0] clr_m);
    logic [MASK_W-1:0] b;
    b = (pin > TOP_PIN) ? '0 : (MASK_W'(1) << pin);
    set_m = set_m & ~b;
    clr_m = clr_m & ~b;
    if (level) set_m = set_m | b;
    else clr_m = clr_m | b;
  endfunction

  function automatic logic any_toggling();
    logic t;
    t = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (used[i] && period_of[i] != 0 && duty_of[i] != 0 && period_of[i] != duty_of[i])
        t = 1'b1;
    end
    return t;
  endfunction

  // Apply one item to the channel table and return the result it should cause.
  function automatic pwm_result_t advance_channel_table(input op_t op,
                                                        input logic [PIN_W-1:0] pin,
                                                        input logic [TICK_W-1:0] period,
                                                        input logic [TICK_W-1:0] duty);
    pwm_result_t       r;
    logic [MASK_W-1:0] s;
    logic [MASK_W-1:0] c;
    int                hit;
    r.status = ST_OK;
    s = '0;
    c = '0;
    hit = -1;
    if (op == OP_TICK) begin
      if (ticking) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (used[i]) begin
            count_of[i] = count_of[i] - 1'b1;
            if (count_of[i] == 0 && duty_of[i] != 0 && duty_of[i] != period_of[i]) begin
              level_of[i] = ~level_of[i];
              drive_pin(pin_of[i], level_of[i], s, c);
              count_of[i] = level_of[i] ? duty_of[i] : period_of[i] - duty_of[i];
            end
          end
        end
      end
    end else if (period != 0 && (period < 2 || duty > period)) begin
      r.status = ST_BAD_ARGS;
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (hit < 0 && used[i] && pin_of[i] == pin) hit = i;
      end
      if (period == 0) begin
        if (hit < 0) begin
          r.status = ST_NO_PIN;
        end else begin
          used[hit] = 1'b0;
          ticking = any_toggling();
          drive_pin(pin, 1'b0, s, c);
        end
      end else begin
        if (hit < 0) begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (hit < 0 && !used[i]) hit = i;
          end
          if (hit >= 0) begin
            used[hit]      = 1'b1;
            pin_of[hit]    = pin;
            level_of[hit]  = 1'b0;
            count_of[hit]  = '0;
            period_of[hit] = '0;
            duty_of[hit]   = '0;
          end
        end
        if (hit < 0) begin
          r.status = ST_FULL;
        end else if (!(period_of[hit] == period && duty_of[hit] == duty)) begin
          period_of[hit] = period;
          duty_of[hit]   = duty;
          // restart high when the counter is spent or beyond the new period
          if (count_of[hit] == 0 || count_of[hit] > period) begin
            level_of[hit] = 1'b1;
            count_of[hit] = duty;
            drive_pin(pin, 1'b1, s, c);
          end
          if (duty == 0 || duty == period) drive_pin(pin, duty == period, s, c);
          ticking = any_toggling();
        end
      end
    end
    r.set_m   = s;
    r.clr_m   = c;
    r.running = ticking;
    return r;
  endfunction

  always @(posedge clk) begin
    pwm_result_t exp_r;
    pwm_result_t got_r;
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) used[i] = 1'b0;
      ticking = 1'b0;
      expected_drives.delete();
    end else begin
      // compare first so a result can never match the item accepted at the same edge
      if (out_tvalid && out_tready) begin
        got_r.status  = status_t'(out_tdata[1:0]);
        got_r.set_m   = out_tdata[18:2];
        got_r.clr_m   = out_tdata[35:19];
        got_r.running = out_tdata[36];
        if (expected_drives.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with nothing expected: st=%0d set=%05h clr=%05h run=%0b",
                     $time, got_r.status, got_r.set_m, got_r.clr_m, got_r.running);
          mismatches++;
        end else begin
          exp_r = expected_drives.pop_front();
          if (got_r.status != exp_r.status || got_r.set_m != exp_r.set_m ||
              got_r.clr_m != exp_r.clr_m || got_r.running != exp_r.running) begin
            if (mismatches < 10)
              $display("%0t: result %0d expected st=%0d set=%05h clr=%05h run=%0b, got st=%0d set=%05h clr=%05h run=%0b",
                       $time, checked_count, exp_r.status, exp_r.set_m, exp_r.clr_m,
                       exp_r.running, got_r.status, got_r.set_m, got_r.clr_m,
                       got_r.running);
            mismatches++;
          end
          checked_count <= checked_count + 1;
          pin_edges <= pin_edges + $countones(exp_r.set_m) + $countones(exp_r.clr_m);
        end
      end
      if (in_tvalid && in_tready)
        expected_drives.push_back(advance_channel_table(op_t'(in_tuser[0]), in_tdata[4:0],
                                                        in_tdata[20:5], in_tdata[36:21]));
    end
    fail_count    <= mismatches;
    pending_count <= expected_drives.size();
  end

endmodule

// ----- tb/tb_multi_channel_pwm_generator_top.sv -----
// Testbench top for the PWM channel table block: drives set and tick items, paces the
// result stream and gives the verdict. Depends on mcpwm_pkg and pwm_table_checker.
module tb_multi_channel_pwm_generator_top;
  import mcpwm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1575;
  localparam int QUIET_LIMIT  = 5000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES  = 400;   // long receiver stall that backs up the block
  localparam int DRAIN_CYCLES = 24;    // a couple of slot walks after the last result

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // pin, period_ticks, duty_ticks, zero pad
  logic [0:0]  in_tuser   = '0;   // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;         // status, set_mask, clear_mask, timer_running, pad

  int fail_count;
  int pending_count;
  int checked_count;
  int pin_edges;

  int snd_idle_pct = 13;
  int phase        = 0;   // 0: slow receiver, 1: slow sender, 2: no idling
  int hold_left    = 0;
  logic held       = 1'b0;
  int quiet_cycles = 0;
  int tick_items   = 0;
  int set_items    = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  multi_channel_pwm_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  pwm_table_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .pin_edges     (pin_edges)
  );

  // Receiver: idle 79% in phase 0, 13% in phase 1, never in phase 2. At the start of
  // phase 2 hold off for a long stretch so the output register and the final step
  // both fill and the block drops in_tready while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (phase == 2 && !held) begin
      held       <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (phase)
        0: begin
          out_tready <= ($urandom_range(0, 99) >= 79);
        end
        1: begin
          out_tready <= ($urandom_range(0, 99) >= 13);
        end
        default: begin
          out_tready <= 1'b1;
        end
      endcase
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_count);
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one item, idling first at the sender's rate; return once it is accepted.
  // Leave in_tvalid high so back-to-back items need no extra drive.
  task automatic send_item(input op_t op, input logic [PIN_W-1:0] pin,
                           input logic [TICK_W-1:0] period, input logic [TICK_W-1:0] duty);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, duty, period, pin};
    do @(posedge clk); while (!in_tready);
    if (op == OP_TICK) tick_items++;
    else set_items++;
  endtask

  initial begin
    int roll;
    int pin;
    int period;
    int duty;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, rejected requests, static levels, high pins, full table.
    send_item(OP_TICK, 0, 0, 0);                 // tick with nothing toggling
    send_item(OP_SET, 2, 1, 0);                  // period below two
    send_item(OP_SET, 2, 5, 6);                  // duty above period
    send_item(OP_SET, 3, 0, 0);                  // remove an unknown pin
    send_item(OP_SET, 16, 4, 1);                 // top pin starts high and toggles
    send_item(OP_SET, 0, 16'hFFFF, 16'hFFFF);    // full duty, static high
    send_item(OP_SET, 1, 2, 0);                  // zero duty, only the low drive shows
    send_item(OP_SET, 31, 3, 1);                 // pin without a mask bit
    send_item(OP_SET, 16, 4, 1);                 // same values again, no drive
    repeat (6) send_item(OP_TICK, 0, 0, 0);
    send_item(OP_SET, 16, 8, 3);                 // update a running channel
    send_item(OP_SET, 4, 16'hFFFF, 16'h8000);
    send_item(OP_SET, 5, 2, 1);
    send_item(OP_SET, 6, 16'h9C40, 1);
    send_item(OP_SET, 7, 3, 2);                  // last free slot
    send_item(OP_SET, 8, 10, 5);                 // table full
    send_item(OP_SET, 31, 0, 0);                 // remove the unmasked pin
    send_item(OP_SET, 16, 0, 0);                 // remove the top pin, drives it low
    send_item(OP_TICK, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0);
    send_item(OP_SET, 0, 0, 16'hFFFF);           // removal ignores duty

    // Random: half ticks so channels keep toggling, sets mostly on a small pin pool.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        snd_idle_pct = 79;
        phase <= 1;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        snd_idle_pct = 0;
        phase <= 2;
      end
      if ($urandom_range(0, 99) < 50) begin
        send_item(OP_TICK, PIN_W'($urandom_range(0, 31)), TICK_W'($urandom_range(0, 65535)),
                  TICK_W'($urandom_range(0, 65535)));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 80) pin = $urandom_range(0, 9);
        else if (roll < 90) pin = TOP_PIN;
        else pin = $urandom_range(17, 31);
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          period = 0;
          duty   = $urandom_range(0, 65535);
        end else if (roll < 22) begin
          if ($urandom_range(0, 1) == 1) begin
            period = 1;
            duty   = $urandom_range(0, 65535);
          end else begin
            period = $urandom_range(2, 65534);
            duty   = $urandom_range(period + 1, 65535);
          end
        end else if (roll < 30) begin
          period = $urandom_range(0, 65535);
          duty   = $urandom_range(0, 65535);
        end else begin
          period = ($urandom_range(0, 99) < 85) ? $urandom_range(2, 24)
                                                : $urandom_range(2, 65535);
          roll = $urandom_range(0, 99);
          if (roll < 12) duty = 0;
          else if (roll < 24) duty = period;
          else duty = $urandom_range(1, period - 1);
        end
        send_item(OP_SET, PIN_W'(pin), TICK_W'(period), TICK_W'(duty));
      end
    end
    in_tvalid <= 1'b0;

    // Drain: wait for every outstanding result, then a few slot walks more.
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ticks and %0d set requests under three pacing phases and a long stall;",
             tick_items, set_items);
    $display("compared %0d results carrying %0d pin drives.", checked_count, pin_edges);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
